// ===== hw/rtl/mse_pkg.sv =====
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types and constants of the MUS score event parser.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int CHANNELS       = 16;
  localparam int NOTE_SLOTS_DEF = 16;
  localparam int MAX_RES        = 3;

  localparam logic [3:0] K_NOTES_OFF  = 4'd0;
  localparam logic [3:0] K_RELEASE    = 4'd1;
  localparam logic [3:0] K_PRESS      = 4'd2;
  localparam logic [3:0] K_PITCH      = 4'd3;
  localparam logic [3:0] K_SYSTEM     = 4'd4;
  localparam logic [3:0] K_VIBRATO    = 4'd5;
  localparam logic [3:0] K_VOLUME     = 4'd6;
  localparam logic [3:0] K_CONTROLLER = 4'd7;
  localparam logic [3:0] K_SCORE_END  = 4'd8;
  localparam logic [3:0] K_GROUP_END  = 4'd9;
  localparam logic [3:0] K_ERROR      = 4'd10;

  // event types, descriptor bits 6..4
  localparam logic [2:0] EV_RELEASE = 3'd0;
  localparam logic [2:0] EV_PRESS   = 3'd1;
  localparam logic [2:0] EV_PITCH   = 3'd2;
  localparam logic [2:0] EV_SYSTEM  = 3'd3;
  localparam logic [2:0] EV_CTRL    = 3'd4;
  localparam logic [2:0] EV_END     = 3'd6;

  localparam logic [3:0] PERC_MUS   = 4'd15;
  localparam logic [3:0] PERC_OUT   = 4'd9;
  localparam logic [3:0] SYS_LO     = 4'd10;
  localparam logic [3:0] SYS_HI     = 4'd14;
  localparam logic [3:0] CTRL_MAX   = 4'd9;
  localparam logic [7:0] CTRL_VIBRATO = 8'd2;
  localparam logic [7:0] CTRL_VOLUME  = 8'd3;
  localparam logic [15:0] HEADER_LEN = 16'd14;
  localparam logic [15:0] POS_START_LO = 16'd6;
  localparam logic [15:0] POS_START_HI = 16'd7;

  localparam logic [7:0] RST_VOLUME = 8'd100;
  localparam logic [7:0] RST_WHEEL  = 8'd128;

  localparam logic [1:0] SRC_EXPLICIT = 2'd0;
  localparam logic [1:0] SRC_CHANNEL  = 2'd1;
  localparam logic [1:0] SRC_GLOBAL   = 2'd2;

  localparam logic CFG_VOLUME = 1'b0;
  localparam logic CFG_WHEEL  = 1'b1;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  channel;
    logic [6:0]  key;
    logic [3:0]  note_index;
    logic [4:0]  note_count;
    logic [7:0]  volume;
    logic [1:0]  volume_source;
    logic [3:0]  controller;
    logic [7:0]  ctrl_value;
    logic [8:0]  delta;
    logic [31:0] gap;
  } result_t;

  // strobes and operands handed to the held-note row
  typedef struct packed {
    logic       press;
    logic       drop;
    logic [7:0] key;
    logic [3:0] ch;
  } note_ctl_t;

  function automatic result_t mk_result(logic [3:0] kind, logic [3:0] ch);
    result_t r;
    r = '0;
    r.kind = kind;
    r.channel = ch;
    return r;
  endfunction

endpackage

// ===== hw/rtl/mse_note_cell.sv =====
// ----------------------------------------------------------------------------
// mse_note_cell
// One held-note slot for every channel; compares against the key and takes
// its right neighbor's note when a release closes the gap.
// ----------------------------------------------------------------------------
module mse_note_cell #(
  parameter int NOTE_SLOTS = mse_pkg::NOTE_SLOTS_DEF,
  parameter int SLOT       = 0
) (
  input  logic                               clk,
  input  mse_pkg::note_ctl_t                 ctl,
  input  logic [$clog2(NOTE_SLOTS+1)-1:0]    cnt,
  input  logic [6:0]                         nb_val,
  input  logic                               hit_in,
  input  logic                               found,
  output logic [6:0]                         val,
  output logic                               own_hit,
  output logic                               hit_out
);
  localparam int CW = $clog2(NOTE_SLOTS + 1);

  logic [6:0] notes [mse_pkg::CHANNELS];

  assign val     = notes[ctl.ch];
  assign own_hit = (cnt > CW'(SLOT)) && ({1'b0, val} == ctl.key);
  assign hit_out = hit_in | own_hit;

  always_ff @(posedge clk) begin
    if (ctl.press && cnt == CW'(SLOT)) begin
      notes[ctl.ch] <= ctl.key[6:0];
    end else if (ctl.drop && found && hit_out && cnt > CW'(SLOT + 1)) begin
      notes[ctl.ch] <= nb_val;
    end
  end

endmodule

// ===== hw/rtl/mse_note_row.sv =====
// ----------------------------------------------------------------------------
// mse_note_row
// Row of held-note cells: search for a key and shift-down on release.
// ----------------------------------------------------------------------------
module mse_note_row #(
  parameter int NOTE_SLOTS = mse_pkg::NOTE_SLOTS_DEF
) (
  input  logic                               clk,
  input  mse_pkg::note_ctl_t                 ctl,
  input  logic [$clog2(NOTE_SLOTS+1)-1:0]    cnt,
  output logic                               found,
  output logic [$clog2(NOTE_SLOTS)-1:0]      idx
);
  localparam int IW = $clog2(NOTE_SLOTS);

  logic [6:0]          vals [NOTE_SLOTS+1];
  logic [NOTE_SLOTS:0] hit_chain;
  logic [NOTE_SLOTS-1:0] own_hit;

  assign vals[NOTE_SLOTS] = '0;
  assign hit_chain[0]     = 1'b0;
  assign found            = hit_chain[NOTE_SLOTS];

  for (genvar j = 0; j < NOTE_SLOTS; j++) begin : g_cell
    mse_note_cell #(.NOTE_SLOTS(NOTE_SLOTS), .SLOT(j)) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .cnt     (cnt),
      .nb_val  (vals[j+1]),
      .hit_in  (hit_chain[j]),
      .found   (found),
      .val     (vals[j]),
      .own_hit (own_hit[j]),
      .hit_out (hit_chain[j+1])
    );
  end

  // lowest matching slot
  always_comb begin
    idx = '0;
    for (int j = NOTE_SLOTS - 1; j >= 0; j--) begin
      if (own_hit[j]) idx = IW'(j);
    end
  end

endmodule

// ===== hw/rtl/mus_score_event_parser.sv =====
// Flow: an accepted byte is decoded in S_EXEC and its results are registered;
// the first result shows in S_OUT in the next cycle, further ones on later transfers.
// Throughput: a new byte is taken only in S_IDLE, once every result of the last
// byte is out; the output gives one result per cycle while out_ready is high.
// Reset: all parse state and channel tables clear at once, registers go to
// volume 100 and wheel 128; no clearing pass.
// ----------------------------------------------------------------------------
// mus_score_event_parser
// MUS byte stream to sequence events, held notes kept in a chain of cells.
// ----------------------------------------------------------------------------
module mus_score_event_parser #(
  parameter int NOTE_SLOTS = mse_pkg::NOTE_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              end_of_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        kind,
  output logic [3:0]        channel,
  output logic [6:0]        key,
  output logic [3:0]        note_index,
  output logic [4:0]        note_count,
  output logic [7:0]        volume,
  output logic [1:0]        volume_source,
  output logic [3:0]        controller,
  output logic [7:0]        ctrl_value,
  output logic signed [8:0] delta,
  output logic [31:0]       gap,
  output logic              last_of_run
);
  localparam int CW = $clog2(NOTE_SLOTS + 1);
  localparam int IW = $clog2(NOTE_SLOTS);
  localparam int NC = mse_pkg::CHANNELS;

  typedef enum logic [6:0] {
    PH_HEADER = 7'b0000001,
    PH_SKIP   = 7'b0000010,
    PH_DESC   = 7'b0000100,
    PH_OP1    = 7'b0001000,
    PH_OP2    = 7'b0010000,
    PH_GAP    = 7'b0100000,
    PH_DONE   = 7'b1000000
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_OUT  = 3'b100
  } st_t;

  st_t    st;
  phase_t phase, phase_next;
  logic [7:0]  cfg_vol, cfg_whl;
  logic [7:0]  bb;
  logic        beod;
  logic [15:0] byte_pos, byte_pos_next, score_start, score_start_next;
  logic [7:0]  pdesc, pdesc_next, pop, pop_next, glast, glast_next;
  logic [31:0] gap_acc, gap_acc_next;
  logic        top_valid, top_valid_next;
  logic [3:0]  top_ch, top_ch_next;
  logic [NC-1:0] map_valid, map_valid_next;
  logic [3:0]  map_ch [NC];
  logic [3:0]  map_ch_next [NC];
  logic [CW-1:0] held_cnt [NC];
  logic [CW-1:0] held_cnt_next [NC];
  logic [7:0]  vol [NC];
  logic [7:0]  vol_next [NC];
  logic [7:0]  vib [NC];
  logic [7:0]  vib_next [NC];
  logic [7:0]  whl [NC];
  logic [7:0]  whl_next [NC];

  mse_pkg::result_t q [mse_pkg::MAX_RES];
  mse_pkg::result_t q_next [mse_pkg::MAX_RES];
  logic [1:0]  nres, nres_next, ptr;

  logic [3:0]  cur_ch;
  logic [CW-1:0] cur_cnt;
  mse_pkg::note_ctl_t nctl;
  logic        found;
  logic [IW-1:0] idx;

  assign cur_ch  = (pdesc[3:0] == mse_pkg::PERC_MUS) ? mse_pkg::PERC_OUT : map_ch[pdesc[3:0]];
  assign cur_cnt = held_cnt[cur_ch];

  always_comb begin
    nctl = '0;
    nctl.ch = cur_ch;
    nctl.key = (phase == PH_OP2) ? pop : bb;
    if (st == S_EXEC && pdesc[6:4] == mse_pkg::EV_PRESS) begin
      nctl.press = (phase == PH_OP1 && !bb[7]) || phase == PH_OP2;
    end
    nctl.drop = st == S_EXEC && phase == PH_OP1 && pdesc[6:4] == mse_pkg::EV_RELEASE;
  end

  mse_note_row #(.NOTE_SLOTS(NOTE_SLOTS)) u_row (
    .clk   (clk),
    .ctl   (nctl),
    .cnt   (cur_cnt),
    .found (found),
    .idx   (idx)
  );

  // decode of one byte
  always_comb begin
    mse_pkg::result_t r;
    logic [1:0]  n;
    logic [3:0]  pick;
    logic [2:0]  ev;
    logic [7:0]  pvol;
    logic [1:0]  psrc;
    logic        do_press, finish;
    r = '0;
    n = '0;
    pick = '0;
    pvol = '0;
    psrc = mse_pkg::SRC_EXPLICIT;
    do_press = 1'b0;
    finish = 1'b0;
    ev = pdesc[6:4];
    phase_next = phase;
    byte_pos_next = byte_pos;
    score_start_next = score_start;
    pdesc_next = pdesc;
    pop_next = pop;
    glast_next = glast;
    gap_acc_next = gap_acc;
    top_valid_next = top_valid;
    top_ch_next = top_ch;
    map_valid_next = map_valid;
    map_ch_next = map_ch;
    held_cnt_next = held_cnt;
    vol_next = vol;
    vib_next = vib;
    whl_next = whl;
    for (int i = 0; i < mse_pkg::MAX_RES; i++) q_next[i] = '0;

    unique case (phase)
      PH_HEADER: begin
        if (byte_pos == mse_pkg::POS_START_LO) score_start_next[7:0] = bb;
        if (byte_pos == mse_pkg::POS_START_HI) score_start_next[15:8] = bb;
        byte_pos_next = byte_pos + 16'd1;
        if (byte_pos == mse_pkg::HEADER_LEN - 16'd1) begin
          if (score_start_next < mse_pkg::HEADER_LEN) begin
            q_next[n] = mse_pkg::mk_result(mse_pkg::K_ERROR, 4'd0);
            n = n + 2'd1;
            phase_next = PH_DONE;
          end else if (score_start_next == mse_pkg::HEADER_LEN) begin
            phase_next = PH_DESC;
          end else begin
            phase_next = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        byte_pos_next = byte_pos + 16'd1;
        if ({1'b0, byte_pos} + 17'd1 >= {1'b0, score_start}) phase_next = PH_DESC;
      end
      PH_DESC: begin
        pdesc_next = bb;
        if (bb[3:0] != mse_pkg::PERC_MUS && !map_valid[bb[3:0]]) begin
          pick = top_valid ? top_ch + 4'd1 : 4'd0;
          if (pick == mse_pkg::PERC_OUT) pick = pick + 4'd1;
          map_valid_next[bb[3:0]] = 1'b1;
          map_ch_next[bb[3:0]] = pick;
          top_valid_next = 1'b1;
          top_ch_next = pick;
          q_next[n] = mse_pkg::mk_result(mse_pkg::K_NOTES_OFF, pick);
          n = n + 2'd1;
        end
        if (bb[6:4] <= mse_pkg::EV_CTRL) begin
          phase_next = PH_OP1;
        end else if (bb[6:4] == mse_pkg::EV_END) begin
          q_next[n] = mse_pkg::mk_result(mse_pkg::K_SCORE_END, 4'd0);
          n = n + 2'd1;
          phase_next = PH_DONE;
        end else begin
          q_next[n] = mse_pkg::mk_result(mse_pkg::K_ERROR, 4'd0);
          n = n + 2'd1;
          phase_next = PH_DONE;
        end
      end
      PH_OP1: begin
        priority case (ev)
          mse_pkg::EV_RELEASE: begin
            if (found) begin
              held_cnt_next[cur_ch] = cur_cnt - CW'(1);
              r = mse_pkg::mk_result(mse_pkg::K_RELEASE, cur_ch);
              r.note_index = 4'(idx);
              r.note_count = 5'(cur_cnt);
              q_next[n] = r;
              n = n + 2'd1;
              finish = 1'b1;
            end else begin
              q_next[n] = mse_pkg::mk_result(mse_pkg::K_ERROR, 4'd0);
              n = n + 2'd1;
              phase_next = PH_DONE;
            end
          end
          mse_pkg::EV_PRESS: begin
            if (bb[7]) begin
              pop_next = bb;
              phase_next = PH_OP2;
            end else begin
              do_press = 1'b1;
              psrc = mse_pkg::SRC_CHANNEL;
            end
          end
          mse_pkg::EV_PITCH: begin
            r = mse_pkg::mk_result(mse_pkg::K_PITCH, cur_ch);
            r.delta = {1'b0, bb} - {1'b0, whl[cur_ch]};
            q_next[n] = r;
            n = n + 2'd1;
            whl_next[cur_ch] = bb;
            finish = 1'b1;
          end
          mse_pkg::EV_SYSTEM: begin
            if (bb < {4'd0, mse_pkg::SYS_LO} || bb > {4'd0, mse_pkg::SYS_HI}) begin
              q_next[n] = mse_pkg::mk_result(mse_pkg::K_ERROR, 4'd0);
              n = n + 2'd1;
              phase_next = PH_DONE;
            end else begin
              r = mse_pkg::mk_result(mse_pkg::K_SYSTEM, cur_ch);
              r.controller = bb[3:0];
              q_next[n] = r;
              n = n + 2'd1;
              finish = 1'b1;
            end
          end
          mse_pkg::EV_CTRL: begin
            pop_next = bb;
            phase_next = PH_OP2;
          end
          default: ;
        endcase
      end
      PH_OP2: begin
        if (ev == mse_pkg::EV_PRESS) begin
          vol_next[cur_ch] = bb;
          do_press = 1'b1;
          if (bb == glast) begin
            psrc = mse_pkg::SRC_GLOBAL;
          end else begin
            glast_next = bb;
            pvol = bb;
          end
        end else if (pop > {4'd0, mse_pkg::CTRL_MAX}) begin
          q_next[n] = mse_pkg::mk_result(mse_pkg::K_ERROR, 4'd0);
          n = n + 2'd1;
          phase_next = PH_DONE;
        end else if (pop == mse_pkg::CTRL_VIBRATO) begin
          r = mse_pkg::mk_result(mse_pkg::K_VIBRATO, cur_ch);
          r.delta = {1'b0, bb} - {1'b0, vib[cur_ch]};
          q_next[n] = r;
          n = n + 2'd1;
          vib_next[cur_ch] = bb;
          finish = 1'b1;
        end else if (pop == mse_pkg::CTRL_VOLUME) begin
          r = mse_pkg::mk_result(mse_pkg::K_VOLUME, cur_ch);
          r.delta = {1'b0, bb} - {1'b0, vol[cur_ch]};
          q_next[n] = r;
          n = n + 2'd1;
          vol_next[cur_ch] = bb;
          finish = 1'b1;
        end else begin
          r = mse_pkg::mk_result(mse_pkg::K_CONTROLLER, cur_ch);
          r.controller = pop[3:0];
          r.ctrl_value = bb;
          q_next[n] = r;
          n = n + 2'd1;
          finish = 1'b1;
        end
      end
      PH_GAP: begin
        gap_acc_next = {gap_acc[24:0], 7'd0} + {25'd0, bb[6:0]};
        if (!bb[7]) begin
          r = mse_pkg::mk_result(mse_pkg::K_GROUP_END, 4'd0);
          r.gap = gap_acc_next;
          q_next[n] = r;
          n = n + 2'd1;
          phase_next = PH_DESC;
        end
      end
      PH_DONE: ;
      default: ;
    endcase

    if (do_press) begin
      if (cur_cnt >= CW'(NOTE_SLOTS)) begin
        q_next[n] = mse_pkg::mk_result(mse_pkg::K_ERROR, 4'd0);
        n = n + 2'd1;
        phase_next = PH_DONE;
      end else begin
        r = mse_pkg::mk_result(mse_pkg::K_PRESS, cur_ch);
        r.key = nctl.key[6:0];
        r.volume = pvol;
        r.volume_source = psrc;
        q_next[n] = r;
        n = n + 2'd1;
        held_cnt_next[cur_ch] = cur_cnt + CW'(1);
        finish = 1'b1;
      end
    end

    if (finish) begin
      if (pdesc[7]) begin
        gap_acc_next = '0;
        phase_next = PH_GAP;
      end else begin
        phase_next = PH_DESC;
      end
    end

    // end of file: truncation check, then a fresh file
    if (beod) begin
      if (phase_next != PH_DONE) begin
        q_next[n] = mse_pkg::mk_result(mse_pkg::K_ERROR, 4'd0);
        n = n + 2'd1;
      end
      phase_next = PH_HEADER;
      byte_pos_next = '0;
      score_start_next = '0;
      pdesc_next = '0;
      pop_next = '0;
      gap_acc_next = '0;
      glast_next = '0;
      top_valid_next = 1'b0;
      top_ch_next = '0;
      map_valid_next = '0;
      for (int i = 0; i < NC; i++) begin
        map_ch_next[i] = '0;
        held_cnt_next[i] = '0;
        vol_next[i] = cfg_vol;
        vib_next[i] = '0;
        whl_next[i] = cfg_whl;
      end
    end
    nres_next = n;
  end

  assign in_ready  = st == S_IDLE;
  assign out_valid = st == S_OUT;
  assign last_of_run = ptr == nres - 2'd1;

  always_comb begin
    mse_pkg::result_t o;
    o = q[ptr];
    kind = o.kind;
    channel = o.channel;
    key = o.key;
    note_index = o.note_index;
    note_count = o.note_count;
    volume = o.volume;
    volume_source = o.volume_source;
    controller = o.controller;
    ctrl_value = o.ctrl_value;
    delta = $signed(o.delta);
    gap = o.gap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      ptr <= '0;
      nres <= '0;
      cfg_vol <= mse_pkg::RST_VOLUME;
      cfg_whl <= mse_pkg::RST_WHEEL;
      phase <= PH_HEADER;
      byte_pos <= '0;
      score_start <= '0;
      pdesc <= '0;
      pop <= '0;
      gap_acc <= '0;
      glast <= '0;
      top_valid <= 1'b0;
      top_ch <= '0;
      map_valid <= '0;
      for (int i = 0; i < NC; i++) begin
        map_ch[i] <= '0;
        held_cnt[i] <= '0;
        vol[i] <= mse_pkg::RST_VOLUME;
        vib[i] <= '0;
        whl[i] <= mse_pkg::RST_WHEEL;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          mse_pkg::CFG_VOLUME: cfg_vol <= cfg_data;
          mse_pkg::CFG_WHEEL:  cfg_whl <= cfg_data;
          default: ;
        endcase
      end
      unique case (st)
        S_IDLE: begin
          if (in_valid) begin
            bb <= in_byte;
            beod <= end_of_data;
            st <= S_EXEC;
          end
        end
        S_EXEC: begin
          phase <= phase_next;
          byte_pos <= byte_pos_next;
          score_start <= score_start_next;
          pdesc <= pdesc_next;
          pop <= pop_next;
          gap_acc <= gap_acc_next;
          glast <= glast_next;
          top_valid <= top_valid_next;
          top_ch <= top_ch_next;
          map_valid <= map_valid_next;
          map_ch <= map_ch_next;
          held_cnt <= held_cnt_next;
          vol <= vol_next;
          vib <= vib_next;
          whl <= whl_next;
          q <= q_next;
          nres <= nres_next;
          ptr <= '0;
          st <= (nres_next == 2'd0) ? S_IDLE : S_OUT;
        end
        S_OUT: begin
          // one result per transfer
          if (out_ready) begin
            if (last_of_run) st <= S_IDLE;
            else ptr <= ptr + 2'd1;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule
